FILE: design/assert_macros.svh
// assertion helpers included by the correlator design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: design/tcc_pkg.sv
`default_nettype none

package tcc_pkg;

   // size limits
   localparam int MAX_SRC_WIDTH  = 1024;
   localparam int MAX_TPL_WIDTH  = 32;
   localparam int MAX_TPL_HEIGHT = 32;
   localparam int RDIM_MAX       = 1024;

   // fixed field and register widths
   localparam int PIX_W  = 8;
   localparam int SRC_W  = 11;
   localparam int TPLW_W = 6;
   localparam int RES_W  = 11;
   localparam int ROW_W  = 11;
   localparam int OUT_W  = 10;
   localparam int ACC_W  = 26;
   localparam int PROD_W = 2 * PIX_W;
   localparam int CSR_AW = 5;
   localparam int CSR_DW = 32;

   // derived widths
   localparam int SW_W      = $clog2(MAX_SRC_WIDTH + 1);
   localparam int COL_W     = $clog2(MAX_SRC_WIDTH);
   localparam int TW_W      = $clog2(MAX_TPL_WIDTH + 1);
   localparam int TH_W      = $clog2(MAX_TPL_HEIGHT + 1);
   localparam int TC_W      = (MAX_TPL_WIDTH > 1) ? $clog2(MAX_TPL_WIDTH) : 1;
   localparam int TR_W      = (MAX_TPL_HEIGHT > 1) ? $clog2(MAX_TPL_HEIGHT) : 1;
   localparam int TPL_DEPTH = MAX_TPL_WIDTH * MAX_TPL_HEIGHT;
   localparam int TPL_AW    = (TPL_DEPTH > 1) ? $clog2(TPL_DEPTH) : 1;
   localparam int SZ_W      = TW_W + TH_W;
   localparam int ROW_AW    = TR_W;
   localparam int LINE_AW   = ROW_AW + COL_W;
   localparam int LINE_DEPTH = 2 ** LINE_AW;
   localparam int CW        = ((SW_W > RES_W) ? SW_W : RES_W) + 1;

   // register reset values
   localparam int SRC_WIDTH_RST  = 1024;
   localparam int TPL_WIDTH_RST  = 32;
   localparam int TPL_HEIGHT_RST = 32;
   localparam int RES_WIDTH_RST  = 993;
   localparam int RES_HEIGHT_RST = 993;

   // request operation codes
   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_STREAM = 1'b1;

   // register map, word index
   typedef enum logic [CSR_AW-3:0] {
      REG_SRC_WIDTH  = 3'd0,
      REG_TPL_WIDTH  = 3'd1,
      REG_TPL_HEIGHT = 3'd2,
      REG_RES_WIDTH  = 3'd3,
      REG_RES_HEIGHT = 3'd4
   } csr_reg_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   // multiply-accumulate control
   typedef struct packed {
      logic clear;
      logic valid;
   } mac_ctrl_type;

endpackage

`default_nettype wire

FILE: design/template_cross_correlation.sv
// A load request, or a source pixel that completes no window, leaves the block ready for
// the next request. A pixel that completes a window holds the block while it issues one
// multiply-accumulate per template pixel, drains the read, product and accumulate pipeline
// and hands over the sum once the previous result, if any, has been taken by rsp_ready.
// Synchronous active-high reset clears control, restores registers, keeps memories.
`default_nettype none

`include "assert_macros.svh"

module template_cross_correlation (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // request channel
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic                         req_operation,
   input  wire logic [tcc_pkg::PIX_W-1:0]    req_pixel,
   // result channel
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic      [tcc_pkg::ACC_W-1:0]    rsp_correlation,
   output logic      [tcc_pkg::OUT_W-1:0]    rsp_result_row,
   output logic      [tcc_pkg::OUT_W-1:0]    rsp_result_col,
   output logic                              rsp_last,
   // register port
   input  wire logic                         csr_psel,
   input  wire logic                         csr_penable,
   input  wire logic                         csr_pwrite,
   input  wire logic [tcc_pkg::CSR_AW-1:0]   csr_paddr,
   input  wire logic [tcc_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic      [tcc_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                              csr_pready
);

   import tcc_pkg::*;

   // configuration registers
   logic [SRC_W-1:0]  cfg_src_width_ff;
   logic [TPLW_W-1:0] cfg_tpl_width_ff;
   logic [TPLW_W-1:0] cfg_tpl_height_ff;
   logic [RES_W-1:0]  cfg_res_width_ff;
   logic [RES_W-1:0]  cfg_res_height_ff;
   logic              csr_wr;
   csr_reg_type       csr_idx;

   // stream position and template load index
   logic [ROW_W-1:0]  src_row_ff, src_row_in;
   logic [COL_W-1:0]  src_col_ff, src_col_in;
   logic [TPL_AW-1:0] load_idx_ff, load_idx_in;

   // clamped sizes and window decode
   logic [SW_W-1:0]   sw;
   logic [TW_W-1:0]   tw;
   logic [TH_W-1:0]   th;
   logic [SZ_W-1:0]   size_full;
   logic [SZ_W-1:0]   idx_cur, idx_eff, idx_inc;
   logic [CW-1:0]     rwe, rwe_geom, rhe;
   logic [CW-1:0]     win_r, win_c;
   logic              win_hit;
   logic              win_last;
   logic              col_end, row_wrap;

   // handshakes
   logic              req_fire, load_fire, stream_fire, start;

   // sequencer
   state_type         state_ff, state_in;
   logic              issue, out_load, last_issue;
   logic [TC_W-1:0]   tc_ff, tc_in, twm1_ff, twm1_in;
   logic [TR_W-1:0]   tr_ff, tr_in, thm1_ff, thm1_in;
   logic [TPL_AW-1:0] tpl_addr_ff, tpl_addr_in;
   logic [ROW_AW-1:0] slot_ff, slot_in;
   logic [COL_W-1:0]  lcol_ff, lcol_in, cbase_ff, cbase_in;
   logic              rd_valid_ff;

   // result tag and result register
   logic [OUT_W-1:0]  tag_row_ff, tag_row_in, tag_col_ff, tag_col_in;
   logic              tag_last_ff, tag_last_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ACC_W-1:0]  rsp_corr_ff;
   logic [OUT_W-1:0]  rsp_row_ff, rsp_col_ff;
   logic              rsp_last_ff;

   // memory and mac wiring
   logic [PIX_W-1:0]  tpl_rd_data, line_rd_data;
   logic [LINE_AW-1:0] line_wr_addr, line_rd_addr;
   mac_ctrl_type      mac_ctrl;
   logic [ACC_W-1:0]  mac_acc;
   logic              mac_busy;

   // register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_reg_type'(csr_paddr[CSR_AW-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_src_width_ff  <= SRC_W'(SRC_WIDTH_RST);
         cfg_tpl_width_ff  <= TPLW_W'(TPL_WIDTH_RST);
         cfg_tpl_height_ff <= TPLW_W'(TPL_HEIGHT_RST);
         cfg_res_width_ff  <= RES_W'(RES_WIDTH_RST);
         cfg_res_height_ff <= RES_W'(RES_HEIGHT_RST);
      end else if (csr_wr) begin
         case (csr_idx)
            REG_SRC_WIDTH:  cfg_src_width_ff  <= csr_pwdata[SRC_W-1:0];
            REG_TPL_WIDTH:  cfg_tpl_width_ff  <= csr_pwdata[TPLW_W-1:0];
            REG_TPL_HEIGHT: cfg_tpl_height_ff <= csr_pwdata[TPLW_W-1:0];
            REG_RES_WIDTH:  cfg_res_width_ff  <= csr_pwdata[RES_W-1:0];
            REG_RES_HEIGHT: cfg_res_height_ff <= csr_pwdata[RES_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_SRC_WIDTH:  csr_prdata = CSR_DW'(cfg_src_width_ff);
         REG_TPL_WIDTH:  csr_prdata = CSR_DW'(cfg_tpl_width_ff);
         REG_TPL_HEIGHT: csr_prdata = CSR_DW'(cfg_tpl_height_ff);
         REG_RES_WIDTH:  csr_prdata = CSR_DW'(cfg_res_width_ff);
         REG_RES_HEIGHT: csr_prdata = CSR_DW'(cfg_res_height_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // zero sizes act as one, oversized ones saturate
   always_comb begin
      if (cfg_src_width_ff == '0) begin
         sw = SW_W'(1);
      end else if (32'(cfg_src_width_ff) > 32'(MAX_SRC_WIDTH)) begin
         sw = SW_W'(MAX_SRC_WIDTH);
      end else begin
         sw = SW_W'(cfg_src_width_ff);
      end
      if (cfg_tpl_width_ff == '0) begin
         tw = TW_W'(1);
      end else if (32'(cfg_tpl_width_ff) > 32'(MAX_TPL_WIDTH)) begin
         tw = TW_W'(MAX_TPL_WIDTH);
      end else begin
         tw = TW_W'(cfg_tpl_width_ff);
      end
      if (cfg_tpl_height_ff == '0) begin
         th = TH_W'(1);
      end else if (32'(cfg_tpl_height_ff) > 32'(MAX_TPL_HEIGHT)) begin
         th = TH_W'(MAX_TPL_HEIGHT);
      end else begin
         th = TH_W'(cfg_tpl_height_ff);
      end
   end

   // template load index with wrap
   assign size_full = SZ_W'(tw) * SZ_W'(th);
   assign idx_cur   = SZ_W'(load_idx_ff);
   assign idx_eff   = (idx_cur >= size_full) ? '0 : idx_cur;
   assign idx_inc   = idx_eff + SZ_W'(1);
   assign load_idx_in = (idx_inc >= size_full) ? '0 : TPL_AW'(idx_inc);

   // effective result extent
   assign rwe_geom = (CW'(tw) > CW'(sw)) ? '0 : (CW'(sw) - CW'(tw) + CW'(1));
   assign rwe = (CW'(cfg_res_width_ff) < rwe_geom) ? CW'(cfg_res_width_ff) : rwe_geom;
   assign rhe = (CW'(cfg_res_height_ff) > CW'(RDIM_MAX)) ? CW'(RDIM_MAX)
                                                         : CW'(cfg_res_height_ff);

   // window completed by the current pixel
   assign win_r    = CW'(src_row_ff) + CW'(1) - CW'(th);
   assign win_c    = CW'(src_col_ff) + CW'(1) - CW'(tw);
   assign win_hit  = (CW'(src_row_ff) + CW'(1) >= CW'(th)) &&
                     (CW'(src_col_ff) + CW'(1) >= CW'(tw)) &&
                     (win_r < rhe) && (win_c < rwe);
   assign win_last = (win_r + CW'(1) == rhe) && (win_c + CW'(1) == rwe);

   // stream position advance
   assign col_end  = (CW'(src_col_ff) + CW'(1) >= CW'(sw));
   assign row_wrap = (rhe != '0) && (CW'(src_row_ff) >= rhe + CW'(th) - CW'(2));

   always_comb begin
      if (col_end) begin
         src_col_in = '0;
         src_row_in = row_wrap ? '0 : (src_row_ff + ROW_W'(1));
      end else begin
         src_col_in = src_col_ff + COL_W'(1);
         src_row_in = src_row_ff;
      end
   end

   assign req_fire    = req_valid && req_ready;
   assign load_fire   = req_fire && (req_operation == OP_LOAD);
   assign stream_fire = req_fire && (req_operation == OP_STREAM);
   assign start       = stream_fire && win_hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_row_ff  <= '0;
         src_col_ff  <= '0;
         load_idx_ff <= '0;
      end else begin
         if (stream_fire) begin
            src_row_ff <= src_row_in;
            src_col_ff <= src_col_in;
         end
         if (load_fire) begin
            load_idx_ff <= load_idx_in;
         end
      end
   end

   // next state
   assign last_issue = (tc_ff == twm1_ff) && (tr_ff == thm1_ff);

   always_comb begin
      case (state_ff)
         ST_IDLE:  state_in = start ? ST_RUN : ST_IDLE;
         ST_RUN:   state_in = last_issue ? ST_DRAIN : ST_RUN;
         ST_DRAIN: state_in = (!rd_valid_ff && !mac_busy) ? ST_DONE : ST_DRAIN;
         ST_DONE:  state_in = (!rsp_valid_ff || rsp_ready) ? ST_IDLE : ST_DONE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            issue     = 1'b0;
            out_load  = 1'b0;
         end
         ST_RUN: begin
            req_ready = 1'b0;
            issue     = 1'b1;
            out_load  = 1'b0;
         end
         ST_DONE: begin
            req_ready = 1'b0;
            issue     = 1'b0;
            out_load  = !rsp_valid_ff || rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
            issue     = 1'b0;
            out_load  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_valid_ff <= issue;
      end
   end

   // address walk over the template and the window
   always_comb begin
      tc_in       = tc_ff;
      tr_in       = tr_ff;
      tpl_addr_in = tpl_addr_ff;
      slot_in     = slot_ff;
      lcol_in     = lcol_ff;
      cbase_in    = cbase_ff;
      twm1_in     = twm1_ff;
      thm1_in     = thm1_ff;
      tag_row_in  = tag_row_ff;
      tag_col_in  = tag_col_ff;
      tag_last_in = tag_last_ff;
      if (start) begin
         tc_in       = '0;
         tr_in       = '0;
         tpl_addr_in = '0;
         slot_in     = win_r[ROW_AW-1:0];
         lcol_in     = COL_W'(win_c);
         cbase_in    = COL_W'(win_c);
         twm1_in     = TC_W'(tw - TW_W'(1));
         thm1_in     = TR_W'(th - TH_W'(1));
         tag_row_in  = OUT_W'(win_r);
         tag_col_in  = OUT_W'(win_c);
         tag_last_in = win_last;
      end else if (issue) begin
         tpl_addr_in = tpl_addr_ff + TPL_AW'(1);
         if (tc_ff == twm1_ff) begin
            tc_in   = '0;
            tr_in   = tr_ff + TR_W'(1);
            slot_in = slot_ff + ROW_AW'(1);
            lcol_in = cbase_ff;
         end else begin
            tc_in   = tc_ff + TC_W'(1);
            lcol_in = lcol_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      tc_ff       <= tc_in;
      tr_ff       <= tr_in;
      tpl_addr_ff <= tpl_addr_in;
      slot_ff     <= slot_in;
      lcol_ff     <= lcol_in;
      cbase_ff    <= cbase_in;
      twm1_ff     <= twm1_in;
      thm1_ff     <= thm1_in;
      tag_row_ff  <= tag_row_in;
      tag_col_ff  <= tag_col_in;
      tag_last_ff <= tag_last_in;
   end

   // template memory
   tcc_ram #(
      .WIDTH (PIX_W),
      .DEPTH (TPL_DEPTH)
   ) u_tpl_ram (
      .clock   (clock),
      .wr_en   (load_fire),
      .wr_addr (TPL_AW'(idx_eff)),
      .wr_data (req_pixel),
      .rd_en   (issue),
      .rd_addr (tpl_addr_ff),
      .rd_data (tpl_rd_data)
   );

   // line memory, one row slot per recent source row
   assign line_wr_addr = {src_row_ff[ROW_AW-1:0], src_col_ff};
   assign line_rd_addr = {slot_ff, lcol_ff};

   tcc_ram #(
      .WIDTH (PIX_W),
      .DEPTH (LINE_DEPTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (stream_fire),
      .wr_addr (line_wr_addr),
      .wr_data (req_pixel),
      .rd_en   (issue),
      .rd_addr (line_rd_addr),
      .rd_data (line_rd_data)
   );

   // shared multiply-accumulate
   assign mac_ctrl.clear = start;
   assign mac_ctrl.valid = rd_valid_ff;

   tcc_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (mac_ctrl),
      .tpl_pix (tpl_rd_data),
      .src_pix (line_rd_data),
      .acc     (mac_acc),
      .busy    (mac_busy)
   );

   // result register
   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_corr_ff <= mac_acc;
         rsp_row_ff  <= tag_row_ff;
         rsp_col_ff  <= tag_col_ff;
         rsp_last_ff <= tag_last_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_correlation = rsp_corr_ff;
   assign rsp_result_row  = rsp_row_ff;
   assign rsp_result_col  = rsp_col_ff;
   assign rsp_last        = rsp_last_ff;

   // checks
   `ASSERT_IMPLIES(a_idle_pipe_empty, clock, reset, req_ready, !rd_valid_ff && !mac_busy)
   `ASSERT_NEXT(a_last_issue_drains, clock, reset, issue && last_issue, state_ff == ST_DRAIN)
   `ASSERT_IMPLIES(a_tpl_addr_in_range, clock, reset, issue, SZ_W'(tpl_addr_ff) < size_full)
   `ASSERT_NEXT(a_result_held, clock, reset, (state_ff == ST_DONE) && rsp_valid_ff && !rsp_ready, state_ff == ST_DONE)
   `ASSERT_IMPLIES(a_result_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_DONE)

endmodule

`default_nettype wire

FILE: design/tcc_ram.sv
`default_nettype none

module tcc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: design/tcc_mac.sv
`default_nettype none

module tcc_mac (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire tcc_pkg::mac_ctrl_type      ctrl,
   input  wire logic [tcc_pkg::PIX_W-1:0]  tpl_pix,
   input  wire logic [tcc_pkg::PIX_W-1:0]  src_pix,
   output logic      [tcc_pkg::ACC_W-1:0]  acc,
   output logic                            busy
);

   import tcc_pkg::*;

   logic [PROD_W-1:0] prod_ff, prod_in;
   logic              prod_valid_ff;
   logic [ACC_W-1:0]  acc_ff, acc_in;

   // product stage
   assign prod_in = PROD_W'(tpl_pix) * PROD_W'(src_pix);

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= ctrl.valid;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // accumulate stage, wraps at the result width
   always_comb begin
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (prod_valid_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc  = acc_ff;
   assign busy = prod_valid_ff;

endmodule

`default_nettype wire

FILE: tb/sv/tcc_result_checker.sv
// watches the request, result and register ports of the correlator,
// predicts every window sum and compares it with the result stream
module tcc_result_checker
   import tcc_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_ready,
   input  wire logic                req_operation,
   input  wire logic [PIX_W-1:0]    req_pixel,
   input  wire logic                rsp_valid,
   input  wire logic                rsp_ready,
   input  wire logic [ACC_W-1:0]    rsp_correlation,
   input  wire logic [OUT_W-1:0]    rsp_result_row,
   input  wire logic [OUT_W-1:0]    rsp_result_col,
   input  wire logic                rsp_last,
   input  wire logic                csr_psel,
   input  wire logic                csr_penable,
   input  wire logic                csr_pwrite,
   input  wire logic [CSR_AW-1:0]   csr_paddr,
   input  wire logic [CSR_DW-1:0]   csr_pwdata,
   input  wire logic                csr_pready,
   output int unsigned              fail_count,
   output int unsigned              pending_count
);

   // one window result
   typedef struct packed {
      logic [ACC_W-1:0] correlation;
      logic [OUT_W-1:0] row;
      logic [OUT_W-1:0] col;
      logic             last;
   } window_sum_type;

   // predicted memories, kept across reset like the block's own
   logic [PIX_W-1:0] tpl_mem  [TPL_DEPTH];
   logic [PIX_W-1:0] line_mem [MAX_TPL_HEIGHT*MAX_SRC_WIDTH];

   int unsigned load_idx, src_row, src_col;
   int unsigned cfg_src_width, cfg_tpl_width, cfg_tpl_height;
   int unsigned cfg_res_width, cfg_res_height;

   window_sum_type expected_windows [$];
   int unsigned mismatches = 0;

   // zero acts as one, large values saturate
   function automatic int unsigned eff_size(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
   endfunction

   // advance the correlator by one request and queue the window it completes
   task automatic step_correlator(input logic op, input logic [PIX_W-1:0] pix);
      int unsigned sw, tw, th, rwe, rhe, r, c, size, idx, acc, t_pix, s_pix;
      window_sum_type w;
      sw = eff_size(cfg_src_width, MAX_SRC_WIDTH);
      tw = eff_size(cfg_tpl_width, MAX_TPL_WIDTH);
      th = eff_size(cfg_tpl_height, MAX_TPL_HEIGHT);

      // template load, index wraps at the template size
      if (op == OP_LOAD) begin
         size = tw * th;
         idx = load_idx;
         if (idx >= size) idx = 0;
         tpl_mem[idx] = pix;
         idx++;
         load_idx = (idx >= size) ? 0 : idx;
         return;
      end

      // effective result extent
      rwe = (tw > sw) ? 0 : sw - tw + 1;
      if (cfg_res_width < rwe) rwe = cfg_res_width;
      rhe = (cfg_res_height > RDIM_MAX) ? RDIM_MAX : cfg_res_height;

      if (src_col < MAX_SRC_WIDTH)
         line_mem[(src_row % MAX_TPL_HEIGHT) * MAX_SRC_WIDTH + src_col] = pix;

      // window whose bottom-right corner is this pixel
      if (src_row + 1 >= th && src_col + 1 >= tw) begin
         r = src_row + 1 - th;
         c = src_col + 1 - tw;
         if (r < rhe && c < rwe) begin
            acc = 0;
            for (int unsigned tr = 0; tr < th; tr++) begin
               for (int unsigned tc = 0; tc < tw; tc++) begin
                  t_pix = tpl_mem[tr * tw + tc];
                  s_pix = line_mem[((r + tr) % MAX_TPL_HEIGHT) * MAX_SRC_WIDTH + c + tc];
                  acc += t_pix * s_pix;
               end
            end
            w.correlation = ACC_W'(acc);
            w.row         = OUT_W'(r);
            w.col         = OUT_W'(c);
            w.last        = (r + 1 == rhe && c + 1 == rwe);
            expected_windows.push_back(w);
         end
      end

      // source position, new image after the last window row
      if (src_col + 1 >= sw) begin
         src_col = 0;
         if (rhe > 0 && src_row >= rhe + th - 2) src_row = 0;
         else src_row = (src_row + 1) & 32'h7FF;
      end else begin
         src_col++;
      end
   endtask

   always @(posedge clock) begin
      window_sum_type want;
      if (reset) begin
         expected_windows.delete();
         load_idx       = 0;
         src_row        = 0;
         src_col        = 0;
         cfg_src_width  = SRC_WIDTH_RST;
         cfg_tpl_width  = TPL_WIDTH_RST;
         cfg_tpl_height = TPL_HEIGHT_RST;
         cfg_res_width  = RES_WIDTH_RST;
         cfg_res_height = RES_HEIGHT_RST;
      end else begin
         // register writes
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_reg_type'(csr_paddr[CSR_AW-1:2]))
               REG_SRC_WIDTH:  cfg_src_width  = csr_pwdata[SRC_W-1:0];
               REG_TPL_WIDTH:  cfg_tpl_width  = csr_pwdata[TPLW_W-1:0];
               REG_TPL_HEIGHT: cfg_tpl_height = csr_pwdata[TPLW_W-1:0];
               REG_RES_WIDTH:  cfg_res_width  = csr_pwdata[RES_W-1:0];
               REG_RES_HEIGHT: cfg_res_height = csr_pwdata[RES_W-1:0];
               default: ;
            endcase
         end

         // accepted request
         if (req_valid && req_ready)
            step_correlator(req_operation, req_pixel);

         // accepted result against the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (expected_windows.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: corr %0d row %0d col %0d last %0b",
                           rsp_correlation, rsp_result_row, rsp_result_col, rsp_last);
            end else begin
               want = expected_windows.pop_front();
               if (rsp_correlation !== want.correlation || rsp_result_row !== want.row ||
                   rsp_result_col !== want.col || rsp_last !== want.last) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("result mismatch: expected corr %0d row %0d col %0d last %0b",
                              want.correlation, want.row, want.col, want.last);
                     $display("                 got corr %0d row %0d col %0d last %0b",
                              rsp_correlation, rsp_result_row, rsp_result_col, rsp_last);
                  end
               end
            end
         end
      end
      fail_count    <= mismatches;
      pending_count <= expected_windows.size();
   end

endmodule

FILE: tb/sv/template_cross_correlation_test.sv
// drives template loads, source images and register settings into the
// correlator; the checker beside it predicts and compares
module template_cross_correlation_test;
   import tcc_pkg::*;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic                req_operation;
   logic [PIX_W-1:0]    req_pixel;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [ACC_W-1:0]    rsp_correlation;
   logic [OUT_W-1:0]    rsp_result_row;
   logic [OUT_W-1:0]    rsp_result_col;
   logic                rsp_last;
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [CSR_AW-1:0]   csr_paddr;
   logic [CSR_DW-1:0]   csr_pwdata;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   int unsigned fail_count;
   int unsigned pending_count;
   int unsigned requests_sent = 0;
   int unsigned ready_hold = 0;
   bit          no_gaps = 1'b0;

   // size extremes run right after the directed part
   int unsigned corner_shapes [5][5] = '{
      '{2047, 5, 1, 3, 2047},
      '{4, 63, 2, 4, 1},
      '{33, 32, 1, 2047, 2},
      '{2, 1, 63, 2, 1},
      '{3, 2, 2, 3, 0}
   };

   template_cross_correlation uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_pixel       (req_pixel),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_correlation (rsp_correlation),
      .rsp_result_row  (rsp_result_row),
      .rsp_result_col  (rsp_result_col),
      .rsp_last        (rsp_last),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   tcc_result_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_pixel       (req_pixel),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_correlation (rsp_correlation),
      .rsp_result_row  (rsp_result_row),
      .rsp_result_col  (rsp_result_col),
      .rsp_last        (rsp_last),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_pready      (csr_pready),
      .fail_count      (fail_count),
      .pending_count   (pending_count)
   );

   // clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // result back-pressure: short stalls, a few long ones, some long open stretches
   always @(posedge clock) begin
      if (ready_hold != 0) begin
         ready_hold--;
      end else if (rsp_ready) begin
         rsp_ready <= 1'b0;
         ready_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                                  : $urandom_range(0, 2);
      end else begin
         rsp_ready <= 1'b1;
         ready_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(0, 20);
      end
   end

   // run limit
   initial begin
      #48000000;
      $display("Verification failed");
      $finish;
   end

   function automatic int unsigned clip(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
   endfunction

   // mostly uniform, with the extremes weighted up
   function automatic logic [PIX_W-1:0] pick_pixel();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return PIX_W'($urandom_range(0, 255));
      endcase
   endfunction

   // one request with a random lead-in gap
   task automatic send_request(input logic op, input logic [PIX_W-1:0] pix);
      int unsigned gap, roll;
      roll = $urandom_range(0, 99);
      if (no_gaps || roll < 55) gap = 0;
      else if (roll < 90) gap = $urandom_range(1, 3);
      else gap = $urandom_range(8, 40);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_pixel     <= pix;
      do @(posedge clock); while (!req_ready);
      requests_sent++;
   endtask

   // stop sending and let every predicted window come out
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (20) @(posedge clock);
   endtask

   // write all five size registers back to back
   task automatic apply_shape(input int unsigned sw, tw, th, rw, rh);
      int unsigned vals [5];
      vals = '{sw, tw, th, rw, rh};
      drain_results();
      for (int i = 0; i < 5; i++) begin
         csr_psel    <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite  <= 1'b1;
         csr_paddr   <= {csr_reg_type'(i), 2'b00};
         csr_pwdata  <= vals[i];
         @(posedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // one pixel under a 1x1 window with no results ends any row and image,
   // so the next image starts at row 0 column 0
   task automatic restart_image(input int unsigned sw, tw, th, rw, rh);
      apply_shape(1, 1, 1, 0, 1);
      send_request(OP_STREAM, pick_pixel());
      apply_shape(sw, tw, th, rw, rh);
   endtask

   task automatic load_template(input int unsigned n, input int fixed_pix);
      for (int unsigned i = 0; i < n; i++)
         send_request(OP_LOAD, (fixed_pix < 0) ? pick_pixel() : PIX_W'(fixed_pix));
   endtask

   // source pixels, random or fixed; random ones come with an occasional stray template load
   task automatic stream_pixels(input int unsigned n, input int fixed_pix);
      for (int unsigned i = 0; i < n; i++) begin
         if (fixed_pix < 0 && $urandom_range(0, 19) == 0)
            send_request(OP_LOAD, pick_pixel());
         send_request(OP_STREAM, (fixed_pix < 0) ? pick_pixel() : PIX_W'(fixed_pix));
      end
   endtask

   // full template, then one or two images, sometimes cut short
   task automatic run_shape(input int unsigned sw, tw, th, rw, rh);
      int unsigned swe, twe, the, rhe, pixels;
      swe = clip(sw, MAX_SRC_WIDTH);
      twe = clip(tw, MAX_TPL_WIDTH);
      the = clip(th, MAX_TPL_HEIGHT);
      rhe = (rh > RDIM_MAX) ? RDIM_MAX : rh;
      restart_image(sw, tw, th, rw, rh);
      no_gaps = ($urandom_range(0, 3) == 0);
      load_template(twe * the, -1);
      pixels = (rhe + the - 1) * swe * $urandom_range(1, 2);
      if (rhe == 0 || pixels > 140) pixels = $urandom_range(8, 40);
      if ($urandom_range(0, 4) == 0) pixels = $urandom_range(1, pixels);
      stream_pixels(pixels, -1);
   endtask

   initial begin
      int unsigned sw, tw, th, rw, rh, base;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_operation = OP_LOAD;
      req_pixel     = '0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset sizes: a partial template and pixels that complete no window
      send_request(OP_LOAD, 8'd0);
      send_request(OP_LOAD, 8'd255);
      send_request(OP_STREAM, 8'd255);
      send_request(OP_STREAM, 8'd0);

      // full-scale 2x2 template over a 3-wide image, width register clamped
      restart_image(3, 2, 2, 2047, 1);
      load_template(4, 255);
      stream_pixels(6, 255);

      // zero sizes act as one, two result rows
      restart_image(0, 0, 0, 5, 2);
      load_template(1, 255);
      stream_pixels(3, 0);

      // template wider than the image gives nothing
      restart_image(2, 3, 1, 1, 1);
      load_template(3, 128);
      stream_pixels(2, 1);

      // size corners, then random shapes
      base = requests_sent;
      for (int i = 0; i < 5; i++)
         run_shape(corner_shapes[i][0], corner_shapes[i][1], corner_shapes[i][2],
                   corner_shapes[i][3], corner_shapes[i][4]);
      while (requests_sent - base < 580) begin
         case ($urandom_range(0, 15))
            0: sw = 0;
            1: sw = 1024;
            2: sw = 2047;
            default: sw = $urandom_range(1, 10);
         endcase
         case ($urandom_range(0, 15))
            0: tw = 0;
            1: tw = 32;
            2: tw = 63;
            default: tw = $urandom_range(1, 4);
         endcase
         case ($urandom_range(0, 15))
            0: th = 0;
            1: th = 32;
            2: th = 63;
            default: th = $urandom_range(1, 4);
         endcase
         if (clip(tw, MAX_TPL_WIDTH) * clip(th, MAX_TPL_HEIGHT) > 64)
            th = $urandom_range(0, 2);
         case ($urandom_range(0, 9))
            0: rw = 0;
            1: rw = 2047;
            default: rw = $urandom_range(1, clip(sw, MAX_SRC_WIDTH) + 1);
         endcase
         case ($urandom_range(0, 11))
            0: rh = 0;
            1: rh = 2047;
            default: rh = $urandom_range(1, 3);
         endcase
         run_shape(sw, tw, th, rw, rh);
      end

      // let the block go quiet, long enough for one worst-case window
      no_gaps = 1'b0;
      drain_results();
      repeat (1100) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

FILE: template_cross_correlation.f
+incdir+design
design/tcc_pkg.sv
design/tcc_ram.sv
design/tcc_mac.sv
design/template_cross_correlation.sv
tb/sv/tcc_result_checker.sv
tb/sv/template_cross_correlation_test.sv
